// ----- design/qos_pkg.sv -----
// shared package for the queue occupancy statistics block
// holds field widths, event kinds, controller states and the command bundle
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package qos_pkg;

    localparam int OCC_BITS_DEF  = 16;
    localparam int FRAC_BITS_DEF = 16;

    localparam int KIND_W    = 2;
    localparam int TS_W      = 32;
    localparam int WAIT_W    = 32;
    localparam int OCC_OUT_W = 16;
    localparam int CNT_W     = 32;
    localparam int MIS_W     = 32;
    localparam int MWAIT_W   = 48;
    localparam int SUM_W     = 64;

    typedef enum logic [KIND_W-1:0] {
        KIND_ARRIVAL = 2'd0,
        KIND_DEPART  = 2'd1,
        KIND_OBSERVE = 2'd2,
        KIND_CLEAR   = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_UPD,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load_in;
        logic mul_en;
        logic upd_en;
        logic div_start;
        logic out_load;
    } cmd_t;

endpackage

`default_nettype wire

// ----- design/qos_div.sv -----
// iterative restoring divider, one quotient bit per cycle
// computes floor((num << FRAC_BITS) / den), all ones when it exceeds Q_W bits
// depends on nothing beyond its parameters
`timescale 1ns / 1ps
`default_nettype none

module qos_div #(
    parameter int NUM_W     = 64,
    parameter int DEN_W     = 32,
    parameter int Q_W       = 32,
    parameter int FRAC_BITS = 16
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic                  done,
    output logic [Q_W-1:0]        quotient
);

    localparam int STEPS  = NUM_W + FRAC_BITS;
    localparam int STEP_W = $clog2(STEPS);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0]  num_reg, num_next;
    logic [DEN_W-1:0]  den_reg, den_next;
    logic [DEN_W-1:0]  rem_reg, rem_next;
    logic [Q_W-1:0]    q_reg, q_next;
    logic              ovf_reg, ovf_next;

    logic [DEN_W:0]    trial;
    logic              fits;

    assign trial = {rem_reg, num_reg[NUM_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        ovf_next  = ovf_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            num_next  = num;
            den_next  = den;
            rem_next  = '0;
            q_next    = '0;
            ovf_next  = 1'b0;
        end
        else if (busy_reg)
        begin
            // a bit leaving the top of the quotient means overflow
            ovf_next = ovf_reg | q_reg[Q_W-1];
            q_next   = {q_reg[Q_W-2:0], fits};
            rem_next = fits ? DEN_W'(trial - {1'b0, den_reg}) : DEN_W'(trial);
            num_next = {num_reg[NUM_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == STEP_W'(STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
        ovf_reg <= ovf_next;
    end

    assign done     = done_reg;
    assign quotient = ovf_reg ? '1 : q_reg;

endmodule

`default_nettype wire

// ----- design/qos_datapath.sv -----
// datapath: event registers, statistics state, area multiplier, two dividers, result registers
// depends on qos_pkg and qos_div
`timescale 1ns / 1ps
`default_nettype none

module qos_datapath #(
    parameter int OCC_BITS  = qos_pkg::OCC_BITS_DEF,
    parameter int FRAC_BITS = qos_pkg::FRAC_BITS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire qos_pkg::cmd_t                    cmd,
    output logic                                  div_done,
    input  wire logic [qos_pkg::KIND_W-1:0]       kind,
    input  wire logic [qos_pkg::TS_W-1:0]         timestamp,
    input  wire logic [qos_pkg::WAIT_W-1:0]       wait_time,
    output logic [qos_pkg::OCC_OUT_W-1:0]         occupancy,
    output logic [qos_pkg::CNT_W-1:0]             arrival_count,
    output logic [qos_pkg::MIS_W-1:0]             mean_in_system,
    output logic [qos_pkg::MWAIT_W-1:0]           mean_wait
);

    localparam int PROD_W = qos_pkg::TS_W + OCC_BITS;

    qos_pkg::kind_t               kind_reg;
    logic [qos_pkg::TS_W-1:0]     ts_reg;
    logic [qos_pkg::WAIT_W-1:0]   wt_reg;

    logic [qos_pkg::TS_W-1:0]     last_time_reg, last_time_next;
    logic [OCC_BITS-1:0]          items_reg, items_next;
    logic [qos_pkg::SUM_W-1:0]    area_reg, area_next;
    logic [qos_pkg::CNT_W-1:0]    arr_reg, arr_next;
    logic [qos_pkg::SUM_W-1:0]    wsum_reg, wsum_next;
    logic [qos_pkg::SUM_W-1:0]    prod_reg;

    logic [qos_pkg::TS_W-1:0]     delta;
    logic [PROD_W-1:0]            prod_full;
    logic [qos_pkg::SUM_W:0]      area_add;
    logic [qos_pkg::SUM_W:0]      wsum_add;

    logic                         mis_done;
    logic                         mw_done;
    logic [qos_pkg::MIS_W-1:0]    mis_q;
    logic [qos_pkg::MWAIT_W-1:0]  mw_q;

    logic [qos_pkg::OCC_OUT_W-1:0] occ_reg;
    logic [qos_pkg::CNT_W-1:0]     cnt_out_reg;
    logic [qos_pkg::MIS_W-1:0]     mis_reg;
    logic [qos_pkg::MWAIT_W-1:0]   mw_reg;

    // event capture
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            kind_reg <= qos_pkg::kind_t'(kind);
            ts_reg   <= timestamp;
            wt_reg   <= wait_time;
        end
    end

    // area increment, only when time moves forward
    assign delta     = ts_reg - last_time_reg;
    assign prod_full = PROD_W'(delta) * PROD_W'(items_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            prod_reg <= (ts_reg > last_time_reg) ? qos_pkg::SUM_W'(prod_full) : '0;
        end
    end

    assign area_add = {1'b0, area_reg} + {1'b0, prod_reg};
    assign wsum_add = {1'b0, wsum_reg} + (qos_pkg::SUM_W + 1)'(wt_reg);

    always_comb
    begin
        last_time_next = last_time_reg;
        items_next     = items_reg;
        area_next      = area_reg;
        arr_next       = arr_reg;
        wsum_next      = wsum_reg;
        unique case (kind_reg)
            qos_pkg::KIND_ARRIVAL:
            begin
                area_next      = area_add[qos_pkg::SUM_W] ? '1 : area_add[qos_pkg::SUM_W-1:0];
                last_time_next = ts_reg;
                if (items_reg != '1)
                begin
                    items_next = items_reg + 1'b1;
                end
                if (arr_reg != '1)
                begin
                    arr_next = arr_reg + 1'b1;
                end
            end
            qos_pkg::KIND_DEPART:
            begin
                area_next      = area_add[qos_pkg::SUM_W] ? '1 : area_add[qos_pkg::SUM_W-1:0];
                last_time_next = ts_reg;
                if (items_reg != '0)
                begin
                    items_next = items_reg - 1'b1;
                end
                wsum_next = wsum_add[qos_pkg::SUM_W] ? '1 : wsum_add[qos_pkg::SUM_W-1:0];
            end
            qos_pkg::KIND_OBSERVE:
            begin
                last_time_next = last_time_reg;
            end
            qos_pkg::KIND_CLEAR:
            begin
                last_time_next = '0;
                items_next     = '0;
                area_next      = '0;
                arr_next       = '0;
                wsum_next      = '0;
            end
            default:
            begin
                last_time_next = last_time_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_time_reg <= '0;
            items_reg     <= '0;
            area_reg      <= '0;
            arr_reg       <= '0;
            wsum_reg      <= '0;
        end
        else if (cmd.upd_en)
        begin
            last_time_reg <= last_time_next;
            items_reg     <= items_next;
            area_reg      <= area_next;
            arr_reg       <= arr_next;
            wsum_reg      <= wsum_next;
        end
    end

    qos_div #(
        .NUM_W     (qos_pkg::SUM_W),
        .DEN_W     (qos_pkg::TS_W),
        .Q_W       (qos_pkg::MIS_W),
        .FRAC_BITS (FRAC_BITS)
    ) u_div_mis (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .num      (area_reg),
        .den      (ts_reg),
        .done     (mis_done),
        .quotient (mis_q)
    );

    qos_div #(
        .NUM_W     (qos_pkg::SUM_W),
        .DEN_W     (qos_pkg::CNT_W),
        .Q_W       (qos_pkg::MWAIT_W),
        .FRAC_BITS (FRAC_BITS)
    ) u_div_mw (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .num      (wsum_reg),
        .den      (arr_reg),
        .done     (mw_done),
        .quotient (mw_q)
    );

    // both dividers run the same number of steps
    assign div_done = mis_done & mw_done;

    // result registers, zero divisor reads as zero
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            occ_reg     <= (32'(items_reg) > 32'(16'hFFFF)) ? '1
                                                           : qos_pkg::OCC_OUT_W'(items_reg);
            cnt_out_reg <= arr_reg;
            mis_reg     <= (ts_reg == '0) ? '0 : mis_q;
            mw_reg      <= (arr_reg == '0) ? '0 : mw_q;
        end
    end

    assign occupancy      = occ_reg;
    assign arrival_count  = cnt_out_reg;
    assign mean_in_system = mis_reg;
    assign mean_wait      = mw_reg;

endmodule

`default_nettype wire

// ----- design/qos_ctrl.sv -----
// controller FSM: sequences capture, multiply, update, divide and result hand-off
// depends on qos_pkg
`timescale 1ns / 1ps
`default_nettype none

module qos_ctrl (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_stall,
    output logic           out_valid,
    input  wire logic      out_stall,
    input  wire logic      div_done,
    output qos_pkg::cmd_t  cmd
);

    qos_pkg::state_t state_reg, state_next;
    logic            out_valid_reg, out_valid_next;
    logic            out_free;

    // result register can take a new item when empty or being drained
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            qos_pkg::ST_IDLE:      if (in_valid) state_next = qos_pkg::ST_MUL;
            qos_pkg::ST_MUL:       state_next = qos_pkg::ST_UPD;
            qos_pkg::ST_UPD:       state_next = qos_pkg::ST_DIV_START;
            qos_pkg::ST_DIV_START: state_next = qos_pkg::ST_DIV_WAIT;
            qos_pkg::ST_DIV_WAIT:  if (div_done) state_next = qos_pkg::ST_DONE;
            qos_pkg::ST_DONE:      if (out_free) state_next = qos_pkg::ST_IDLE;
            default:               state_next = qos_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd           = '0;
        cmd.load_in   = (state_reg == qos_pkg::ST_IDLE) && in_valid;
        cmd.mul_en    = (state_reg == qos_pkg::ST_MUL);
        cmd.upd_en    = (state_reg == qos_pkg::ST_UPD);
        cmd.div_start = (state_reg == qos_pkg::ST_DIV_START);
        cmd.out_load  = (state_reg == qos_pkg::ST_DONE) && out_free;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= qos_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != qos_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ----- design/queue_occupancy_statistics.sv -----
// top level of the queue occupancy statistics monitor
// joins qos_ctrl and qos_datapath; depends on qos_pkg
//
// usage
//   input channel (in_valid / in_stall) carries one event item: kind
//   (arrival, departure, observe, clear), timestamp in ticks, and the
//   waiting time of a departing item
//   output channel (out_valid / out_stall) carries one result item per
//   event: occupancy, arrival count, mean number in system (area over
//   timestamp) and mean wait (total wait over arrivals), both fixed point
//   with FRAC_BITS fraction bits, saturating
// event handling
//   one event at a time; the two bit-serial dividers run side by side
//   and produce one quotient bit a cycle; in_stall is high after
//   acceptance until the result is loaded, so a new event is taken only
//   once the result of the last one has been loaded
// stalls
//   the result sits in an output register; while the receiver stalls, the
//   next event is taken and worked on, and only its hand-off waits
// reset
//   rst_n clears the statistics, the controller and the output valid
`timescale 1ns / 1ps
`default_nettype none

module queue_occupancy_statistics #(
    parameter int OCC_BITS  = qos_pkg::OCC_BITS_DEF,
    parameter int FRAC_BITS = qos_pkg::FRAC_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // event items
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [qos_pkg::KIND_W-1:0]    kind,
    input  wire logic [qos_pkg::TS_W-1:0]      timestamp,
    input  wire logic [qos_pkg::WAIT_W-1:0]    wait_time,
    // result items
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [qos_pkg::OCC_OUT_W-1:0]      occupancy,
    output logic [qos_pkg::CNT_W-1:0]          arrival_count,
    output logic [qos_pkg::MIS_W-1:0]          mean_in_system,
    output logic [qos_pkg::MWAIT_W-1:0]        mean_wait
);

    qos_pkg::cmd_t cmd;
    logic          div_done;

    // sequencing: capture, multiply, update state, start divide, hand off
    qos_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .div_done  (div_done),
        .cmd       (cmd)
    );

    // statistics state, area multiplier, dividers and result registers
    qos_datapath #(
        .OCC_BITS  (OCC_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .div_done       (div_done),
        .kind           (kind),
        .timestamp      (timestamp),
        .wait_time      (wait_time),
        .occupancy      (occupancy),
        .arrival_count  (arrival_count),
        .mean_in_system (mean_in_system),
        .mean_wait      (mean_wait)
    );

endmodule

`default_nettype wire
